// File: rtl/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, codes and a character helper for the integer-to-radix-text block.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int unsigned ValueFieldW = 64;
  localparam int unsigned RadixW      = 6;
  localparam int unsigned BufW        = 8;
  localparam int unsigned CharW       = 8;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned DigitW      = 6;
  localparam int unsigned StoreDepth  = 64;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned CfgIdxW     = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgRadix      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSignedMode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBufferSize = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusBadParam = 2'd1;
  localparam logic [StatusW-1:0] StatusTooSmall = 2'd2;

  localparam logic [RadixW-1:0] MinRadix     = 6'd2;
  localparam logic [RadixW-1:0] MaxRadix     = 6'd36;
  localparam logic [RadixW-1:0] DecimalRadix = 6'd10;

  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharMinus  = 8'h2d;

  localparam logic [RadixW-1:0] ResetRadix      = 6'd10;
  localparam logic              ResetSignedMode = 1'b1;
  localparam logic [BufW-1:0]   ResetBufferSize = 8'd65;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic              signed_mode;
    logic [BufW-1:0]   buffer_size;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [ValueFieldW-1:0] mag;
    logic                   neg;
    logic                   err;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_CHECK,
    BK_SIGN,
    BK_RD,
    BK_EMIT,
    BK_STAT
  } back_state_e;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CharZero + dx;
    end else begin
      digit_char = CharLowerA + dx - 8'd10;
    end
  endfunction

endpackage

// File: rtl/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts one value per input transfer into its ASCII text in radix 2..36.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries value_i. Output channel
//   out_valid_o/out_ready_i carries character_o, last_o and status_o; one
//   input transfer yields the characters of the text, most significant
//   first (leading '-' for negative signed decimal), last_o on the final one,
//   or a single status-only transfer (character 0, last 1) when the radix or
//   buffer size is invalid or the text plus terminator exceeds buffer_size.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 radix, 1 signed_mode, 2 buffer_size); write only while idle.
// Operation:
//   Each digit comes from the divider, four quotient bits per cycle; each
//   character is then read back through the registered digit RAM read
//   port (BK_RD, then BK_EMIT). The engine takes one item at a time; a
//   two-entry queue lets the input take items while the engine works.
// Reset: clears the queue, engine and output register; registers return to
//   radix 10, signed mode on, buffer size 65.
// Stall: a held output register stops emission; the input keeps accepting
//   until the queue is full.
// ----------------------------------------------------------------------------
module integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [itr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [itr_pkg::BufW-1:0]        cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [itr_pkg::ValueFieldW-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [itr_pkg::CharW-1:0]       character_o,
  output logic                            last_o,
  output logic [itr_pkg::StatusW-1:0]     status_o
);

  itr_pkg::cfg_t cfg_q;
  itr_pkg::cmd_t front_cmd;
  itr_pkg::cmd_t queue_cmd;
  logic          queue_valid;
  logic          queue_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix       <= itr_pkg::ResetRadix;
      cfg_q.signed_mode <= itr_pkg::ResetSignedMode;
      cfg_q.buffer_size <= itr_pkg::ResetBufferSize;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        itr_pkg::CfgRadix: begin
          cfg_q.radix <= cfg_wdata_i[itr_pkg::RadixW-1:0];
        end
        itr_pkg::CfgSignedMode: begin
          cfg_q.signed_mode <= cfg_wdata_i[0];
        end
        itr_pkg::CfgBufferSize: begin
          cfg_q.buffer_size <= cfg_wdata_i;
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  itr_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .value_i (value_i),
    .cfg_i   (cfg_q),
    .cmd_o   (front_cmd)
  );

  itr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (front_cmd),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_cmd_o   (queue_cmd)
  );

  itr_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_ready_o (queue_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

// File: rtl/itr_ram.sv
// ----------------------------------------------------------------------------
// itr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module itr_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/itr_front.sv
// ----------------------------------------------------------------------------
// itr_front
// Classifies an incoming value: parameter check, sign and magnitude.
// ----------------------------------------------------------------------------
module itr_front #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [itr_pkg::ValueFieldW-1:0] value_i,
  input  itr_pkg::cfg_t                   cfg_i,
  output itr_pkg::cmd_t                   cmd_o
);

  logic [VALUE_WIDTH-1:0] raw;
  logic                   bad_param;
  logic                   neg;

  assign raw = value_i[VALUE_WIDTH-1:0];

  assign bad_param = (cfg_i.radix < itr_pkg::MinRadix) ||
                     (cfg_i.radix > itr_pkg::MaxRadix) ||
                     (cfg_i.buffer_size == '0);

  // minus sign only for signed decimal text
  assign neg = cfg_i.signed_mode && (cfg_i.radix == itr_pkg::DecimalRadix) &&
               raw[VALUE_WIDTH-1];

  always_comb begin
    cmd_o.err = bad_param;
    cmd_o.neg = neg;
    if (neg) begin
      cmd_o.mag = itr_pkg::ValueFieldW'(~raw + 1'b1);
    end else begin
      cmd_o.mag = itr_pkg::ValueFieldW'(raw);
    end
  end

endmodule

// File: rtl/itr_queue.sv
// ----------------------------------------------------------------------------
// itr_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module itr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  itr_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output itr_pkg::cmd_t out_cmd_o
);

  itr_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_cmd_o   = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// File: rtl/itr_back.sv
// ----------------------------------------------------------------------------
// itr_back
// Radix conversion engine: repeated division by the radix, four quotient
// bits per cycle, digits kept in a RAM and emitted most significant first.
// ----------------------------------------------------------------------------
module itr_back #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  itr_pkg::cfg_t                cfg_i,
  input  logic                         cmd_valid_i,
  input  itr_pkg::cmd_t                cmd_i,
  output logic                         cmd_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itr_pkg::CharW-1:0]    character_o,
  output logic                         last_o,
  output logic [itr_pkg::StatusW-1:0]  status_o
);

  localparam int unsigned BitsPerCycle = 4;
  localparam int unsigned PadW  = ((VALUE_WIDTH + BitsPerCycle - 1) / BitsPerCycle) *
                                  BitsPerCycle;
  localparam int unsigned Iters = PadW / BitsPerCycle;
  localparam int unsigned IterW = (Iters > 1) ? $clog2(Iters) : 1;

  itr_pkg::back_state_e state_q, state_d;

  logic [PadW-1:0]                 dvd_q, dvd_d, dvd_n;
  logic [itr_pkg::DigitW-1:0]      rem_q, rem_d, rem_n;
  logic [IterW-1:0]                iter_q, iter_d;
  logic [itr_pkg::CountW-1:0]      count_q, count_d;
  logic [itr_pkg::IdxW-1:0]        idx_q, idx_d;
  logic                            neg_q, neg_d;
  logic [itr_pkg::StatusW-1:0]     stat_q, stat_d;
  logic                            out_valid_q, out_valid_d;
  logic [itr_pkg::CharW-1:0]       char_q, char_d;
  logic                            last_q, last_d;
  logic [itr_pkg::StatusW-1:0]     status_q, status_d;
  logic                            ram_we;
  logic [itr_pkg::DigitW-1:0]      ram_rdata;
  logic                            out_free;
  logic [itr_pkg::BufW-1:0]        text_len;

  // four restoring division steps on the narrow remainder
  always_comb begin
    logic [PadW-1:0]              d;
    logic [itr_pkg::DigitW:0]     r;
    logic [itr_pkg::DigitW-1:0]   rm;
    d  = dvd_q;
    rm = rem_q;
    for (int k = 0; k < BitsPerCycle; k++) begin
      r = {rm, d[PadW-1]};
      d = {d[PadW-2:0], 1'b0};
      if (r >= {1'b0, cfg_i.radix}) begin
        r    = r - {1'b0, cfg_i.radix};
        d[0] = 1'b1;
      end
      rm = r[itr_pkg::DigitW-1:0];
    end
    dvd_n = d;
    rem_n = rm;
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign text_len = itr_pkg::BufW'(count_q) + itr_pkg::BufW'(neg_q) + 8'd1;

  always_comb begin
    state_d     = state_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    iter_d      = iter_q;
    count_d     = count_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    cmd_ready_o = 1'b0;

    case (state_q)
      itr_pkg::BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          neg_d   = cmd_i.neg;
          dvd_d   = PadW'(cmd_i.mag[VALUE_WIDTH-1:0]);
          rem_d   = '0;
          iter_d  = '0;
          count_d = '0;
          if (cmd_i.err) begin
            stat_d  = itr_pkg::StatusBadParam;
            state_d = itr_pkg::BK_STAT;
          end else begin
            state_d = itr_pkg::BK_DIV;
          end
        end
      end
      itr_pkg::BK_DIV: begin
        dvd_d  = dvd_n;
        rem_d  = rem_n;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterW'(Iters - 1)) begin
          // digit done: store it, start on the quotient
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          iter_d  = '0;
          rem_d   = '0;
          if (dvd_n == '0) begin
            state_d = itr_pkg::BK_CHECK;
          end
        end
      end
      itr_pkg::BK_CHECK: begin
        idx_d = itr_pkg::IdxW'(count_q - 1'b1);
        if (text_len > cfg_i.buffer_size) begin
          stat_d  = itr_pkg::StatusTooSmall;
          state_d = itr_pkg::BK_STAT;
        end else if (neg_q) begin
          state_d = itr_pkg::BK_SIGN;
        end else begin
          state_d = itr_pkg::BK_RD;
        end
      end
      itr_pkg::BK_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itr_pkg::CharMinus;
          last_d      = 1'b0;
          status_d    = itr_pkg::StatusOk;
          state_d     = itr_pkg::BK_RD;
        end
      end
      itr_pkg::BK_RD: begin
        // wait for the registered read of digit idx_q
        state_d = itr_pkg::BK_EMIT;
      end
      itr_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = itr_pkg::digit_char(ram_rdata);
          last_d      = (idx_q == '0);
          status_d    = itr_pkg::StatusOk;
          if (idx_q == '0) begin
            state_d = itr_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = itr_pkg::BK_RD;
          end
        end
      end
      itr_pkg::BK_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = '0;
          last_d      = 1'b1;
          status_d    = stat_q;
          state_d     = itr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = itr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itr_pkg::BK_IDLE;
      iter_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    stat_q   <= stat_d;
    char_q   <= char_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  itr_ram #(
    .Width (itr_pkg::DigitW),
    .Depth (itr_pkg::StoreDepth)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[itr_pkg::IdxW-1:0]),
    .wdata_i (rem_n),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= itr_pkg::CountW'(itr_pkg::StoreDepth))
    else $error("digit count beyond store depth");

  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != itr_pkg::StatusOk) |-> (last_q && char_q == '0))
    else $error("status result not a lone last item");

  a_emit_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itr_pkg::BK_RD || state_q == itr_pkg::BK_EMIT) |-> count_q != '0)
    else $error("emission without stored digits");

  a_div_radix_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itr_pkg::BK_DIV |->
      (cfg_i.radix >= itr_pkg::MinRadix && cfg_i.radix <= itr_pkg::MaxRadix))
    else $error("division with invalid radix");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks integer_to_radix_text. A directed table covers reset values, field
// extremes, every bad-parameter and short-buffer case, signed decimal and
// masked register writes. Then random values run under random register
// settings. Each character the block emits is compared with the text typed
// into the table or with an independent SystemVerilog conversion of the value.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          StallLimit  = 20000;
  localparam int          PhaseItems  = 142;
  localparam logic [itr_pkg::CfgIdxW-1:0]     CfgUnused = 2'd3;
  localparam logic [itr_pkg::ValueFieldW-1:0] AllOnes = '1;
  localparam logic [itr_pkg::ValueFieldW-1:0] MostNeg = 64'h8000_0000_0000_0000;
  localparam logic [itr_pkg::ValueFieldW-1:0] MostPos = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [itr_pkg::CharW-1:0]   ch;
    logic                        last;
    logic [itr_pkg::StatusW-1:0] status;
  } char_t;

  typedef struct {
    logic                            wr;      // rewrite the registers first
    logic                            stray;   // also write the unused index
    logic [itr_pkg::BufW-1:0]        radix_w;
    logic [itr_pkg::BufW-1:0]        sign_w;
    logic [itr_pkg::BufW-1:0]        size_w;
    logic [itr_pkg::ValueFieldW-1:0] value;
    logic                            typed;   // expected text given below
    logic [itr_pkg::StatusW-1:0]     status;
    string                           text;
  } probe_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [itr_pkg::CfgIdxW-1:0]     cfg_idx = '0;
  logic [itr_pkg::BufW-1:0]        cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready_o;
  logic [itr_pkg::ValueFieldW-1:0] value = '0;
  logic                            out_valid_o;
  logic                            out_ready = 1'b0;
  logic [itr_pkg::CharW-1:0]       character_o;
  logic                            last_o;
  logic [itr_pkg::StatusW-1:0]     status_o;

  // register copy, updated on observed writes
  logic [itr_pkg::RadixW-1:0] cur_radix = itr_pkg::ResetRadix;
  logic                       cur_sgn   = itr_pkg::ResetSignedMode;
  logic [itr_pkg::BufW-1:0]   cur_buf   = itr_pkg::ResetBufferSize;

  char_t       text_due[$];
  probe_t      probes[$];
  logic        typed_pending = 1'b0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 59;
  int          errors = 0;
  int          quiet = 0;
  int          n_values = 0;
  int          n_chars = 0;
  int          n_flags = 0;
  int          n_settings = 0;

  integer_to_radix_text u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .value_i     (value),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .character_o (character_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Expected characters of one value under the current registers.
  function automatic void spell_value(input logic [itr_pkg::ValueFieldW-1:0] raw);
    logic [itr_pkg::DigitW-1:0]      digs [itr_pkg::StoreDepth];
    logic [itr_pkg::ValueFieldW-1:0] mag;
    logic [itr_pkg::ValueFieldW-1:0] rem;
    logic [itr_pkg::CharW-1:0]       ch;
    logic                            neg;
    int                              ndig;
    int                              i;
    if (cur_radix < itr_pkg::MinRadix || cur_radix > itr_pkg::MaxRadix || cur_buf == '0) begin
      text_due.push_back('{ch: '0, last: 1'b1, status: itr_pkg::StatusBadParam});
      return;
    end
    neg = cur_sgn && (cur_radix == itr_pkg::DecimalRadix) && raw[itr_pkg::ValueFieldW-1];
    mag = neg ? -raw : raw;
    ndig = 0;
    do begin
      rem = mag % cur_radix;
      mag = mag / cur_radix;
      digs[ndig] = rem[itr_pkg::DigitW-1:0];
      ndig++;
    end while (mag != '0);
    if (ndig + neg + 1 > cur_buf) begin
      text_due.push_back('{ch: '0, last: 1'b1, status: itr_pkg::StatusTooSmall});
      return;
    end
    if (neg) begin
      text_due.push_back('{ch: itr_pkg::CharMinus, last: 1'b0, status: itr_pkg::StatusOk});
    end
    for (i = ndig - 1; i >= 0; i--) begin
      ch = {2'b00, digs[i]};
      if (digs[i] < 10) ch = ch + itr_pkg::CharZero;
      else ch = ch + itr_pkg::CharLowerA - 8'd10;
      text_due.push_back('{ch: ch, last: (i == 0), status: itr_pkg::StatusOk});
    end
  endfunction

  // Expected characters typed into the table.
  function automatic void push_typed(input logic [itr_pkg::StatusW-1:0] st,
                                     input string text);
    int i;
    if (st != itr_pkg::StatusOk) begin
      text_due.push_back('{ch: '0, last: 1'b1, status: st});
      return;
    end
    for (i = 0; i < text.len(); i++) begin
      text_due.push_back('{ch: text[i], last: (i == text.len() - 1),
                           status: itr_pkg::StatusOk});
    end
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [itr_pkg::CharW-1:0] want,
                                 input logic [itr_pkg::CharW-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : monitor
    char_t want;
    logic  moved;
    moved = cfg_we || (in_valid && in_ready_o) || (out_valid_o && out_ready);
    if (cfg_we) begin
      case (cfg_idx)
        itr_pkg::CfgRadix:      cur_radix = cfg_wdata[itr_pkg::RadixW-1:0];
        itr_pkg::CfgSignedMode: cur_sgn = cfg_wdata[0];
        itr_pkg::CfgBufferSize: cur_buf = cfg_wdata;
        default: ;
      endcase
    end
    if (in_valid && in_ready_o) begin
      n_values++;
      if (typed_pending) typed_pending = 1'b0;
      else spell_value(value);
    end
    if (out_valid_o && out_ready) begin
      if (status_o == itr_pkg::StatusOk) n_chars++;
      else n_flags++;
      if (text_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none actual %h/%b/%0d",
                 $time, character_o, last_o, status_o);
      end else begin
        want = text_due.pop_front();
        if (character_o !== want.ch) report_mismatch("character", want.ch, character_o);
        if (last_o !== want.last) begin
          report_mismatch("last", itr_pkg::CharW'(want.last), itr_pkg::CharW'(last_o));
        end
        if (status_o !== want.status) begin
          report_mismatch("status", itr_pkg::CharW'(want.status), itr_pkg::CharW'(status_o));
        end
      end
    end
    if (moved) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic probe_t case_row(input logic wr, input logic stray,
                                      input logic [itr_pkg::BufW-1:0] radix_w,
                                      input logic [itr_pkg::BufW-1:0] sign_w,
                                      input logic [itr_pkg::BufW-1:0] size_w,
                                      input logic [itr_pkg::ValueFieldW-1:0] v,
                                      input logic typed,
                                      input logic [itr_pkg::StatusW-1:0] st,
                                      input string text);
    case_row = '{wr: wr, stray: stray, radix_w: radix_w, sign_w: sign_w,
                 size_w: size_w, value: v, typed: typed, status: st, text: text};
  endfunction

  task automatic send_value(input logic [itr_pkg::ValueFieldW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready_o);
  endtask

  // Hold the input until every expected character has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (text_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [itr_pkg::BufW-1:0] radix_w,
                              input logic [itr_pkg::BufW-1:0] sign_w,
                              input logic [itr_pkg::BufW-1:0] size_w, input logic stray);
    n_settings++;
    cfg_we    <= 1'b1;
    cfg_idx   <= itr_pkg::CfgRadix;
    cfg_wdata <= radix_w;
    @(posedge clk);
    cfg_idx   <= itr_pkg::CfgSignedMode;
    cfg_wdata <= sign_w;
    @(posedge clk);
    cfg_idx   <= itr_pkg::CfgBufferSize;
    cfg_wdata <= size_w;
    @(posedge clk);
    if (stray) begin
      cfg_idx   <= CfgUnused;
      cfg_wdata <= '0;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_regs();
    logic [itr_pkg::BufW-1:0] radix_w;
    logic [itr_pkg::BufW-1:0] size_w;
    case ($urandom_range(0, 9))
      0: radix_w = itr_pkg::BufW'($urandom_range(0, 1) ? $urandom_range(0, 1) :
                                                         $urandom_range(37, 63));
      1:       radix_w = {2'b00, itr_pkg::MinRadix};
      2:       radix_w = {2'b00, itr_pkg::MaxRadix};
      3, 4:    radix_w = {2'b00, itr_pkg::DecimalRadix};
      5:       radix_w = 8'd16;
      default: radix_w = itr_pkg::BufW'($urandom_range(2, 36));
    endcase
    radix_w[itr_pkg::BufW-1:itr_pkg::RadixW] = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 15))
      0:             size_w = '0;
      1, 2, 3, 4, 5: size_w = itr_pkg::BufW'($urandom_range(1, 24));
      6, 7:          size_w = itr_pkg::ResetBufferSize;
      8:             size_w = 8'd255;
      default:       size_w = itr_pkg::BufW'($urandom_range(25, 255));
    endcase
    program_regs(radix_w, itr_pkg::BufW'($urandom), size_w, $urandom_range(0, 7) == 0);
  endtask

  function automatic logic [itr_pkg::ValueFieldW-1:0] pick_value();
    logic [itr_pkg::ValueFieldW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       v = itr_pkg::ValueFieldW'($urandom_range(0, 40));
      1:       v = AllOnes;
      2:       v = $urandom_range(0, 1) ? MostNeg : MostPos;
      3:       v = -itr_pkg::ValueFieldW'($urandom_range(1, 1000));
      4, 5:    ;
      default: v = v >> $urandom_range(0, itr_pkg::ValueFieldW - 1);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int phase;
    int sent;
    int burst;
    // reset values first, then extremes and every parameter error
    probes.push_back(case_row(0, 0, 0, 0, 0, '0, 1, itr_pkg::StatusOk, "0"));
    probes.push_back(case_row(0, 0, 0, 0, 0, AllOnes, 1, itr_pkg::StatusOk, "-1"));
    probes.push_back(case_row(0, 0, 0, 0, 0, MostNeg, 1, itr_pkg::StatusOk,
                              "-9223372036854775808"));
    probes.push_back(case_row(0, 0, 0, 0, 0, MostPos, 1, itr_pkg::StatusOk,
                              "9223372036854775807"));
    probes.push_back(case_row(1, 0, 10, 0, 65, AllOnes, 1, itr_pkg::StatusOk,
                              "18446744073709551615"));
    probes.push_back(case_row(1, 0, 16, 0, 65, AllOnes, 1, itr_pkg::StatusOk,
                              "ffffffffffffffff"));
    probes.push_back(case_row(1, 0, 16, 1, 65, 64'hfedc_ba98_7654_3210, 1, itr_pkg::StatusOk,
                              "fedcba9876543210"));
    probes.push_back(case_row(1, 0, 36, 0, 65, 64'd35, 1, itr_pkg::StatusOk, "z"));
    probes.push_back(case_row(1, 0, 36, 0, 65, AllOnes, 0, itr_pkg::StatusOk, ""));
    probes.push_back(case_row(1, 0, 2, 0, 65, AllOnes, 0, itr_pkg::StatusOk, ""));
    probes.push_back(case_row(1, 0, 2, 0, 64, AllOnes, 1, itr_pkg::StatusTooSmall, ""));
    probes.push_back(case_row(1, 0, 2, 1, 255, MostNeg, 0, itr_pkg::StatusOk, ""));
    probes.push_back(case_row(1, 0, 0, 1, 65, 64'd7, 1, itr_pkg::StatusBadParam, ""));
    probes.push_back(case_row(1, 0, 1, 1, 65, 64'd7, 1, itr_pkg::StatusBadParam, ""));
    probes.push_back(case_row(1, 0, 37, 1, 65, 64'd7, 1, itr_pkg::StatusBadParam, ""));
    probes.push_back(case_row(1, 0, 63, 1, 65, 64'd7, 1, itr_pkg::StatusBadParam, ""));
    // upper write-data bits must be dropped
    probes.push_back(case_row(1, 0, 8'hc2, 8'hfe, 65, 64'd5, 1, itr_pkg::StatusOk, "101"));
    probes.push_back(case_row(1, 0, 10, 1, 0, '0, 1, itr_pkg::StatusBadParam, ""));
    probes.push_back(case_row(1, 0, 10, 1, 1, '0, 1, itr_pkg::StatusTooSmall, ""));
    probes.push_back(case_row(1, 0, 10, 1, 2, '0, 1, itr_pkg::StatusOk, "0"));
    probes.push_back(case_row(1, 0, 10, 1, 2, AllOnes, 1, itr_pkg::StatusTooSmall, ""));
    probes.push_back(case_row(1, 0, 10, 1, 3, AllOnes, 1, itr_pkg::StatusOk, "-1"));
    probes.push_back(case_row(1, 0, 10, 0, 20, AllOnes, 1, itr_pkg::StatusTooSmall, ""));
    probes.push_back(case_row(1, 0, 10, 0, 21, AllOnes, 1, itr_pkg::StatusOk,
                              "18446744073709551615"));
    // write to the unused index must change nothing
    probes.push_back(case_row(1, 1, 16, 0, 65, 64'hff, 1, itr_pkg::StatusOk, "ff"));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[k]) begin
      drain();
      if (probes[k].wr)
        program_regs(probes[k].radix_w, probes[k].sign_w, probes[k].size_w, probes[k].stray);
      if (probes[k].typed) begin
        push_typed(probes[k].status, probes[k].text);
        typed_pending = 1'b1;
      end
      send_value(probes[k].value);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 19 : 0;
      sent = 0;
      while (sent < PhaseItems) begin
        drain();
        random_regs();
        burst = $urandom_range(1, 24);
        if (burst > PhaseItems - sent) burst = PhaseItems - sent;
        repeat (burst) send_value(pick_value());
        sent += burst;
      end
    end

    drain();
    repeat (1500) @(posedge clk);
    $display("Converted %0d values under %0d register settings: %0d characters and %0d",
             n_values, n_settings, n_chars, n_flags);
    $display("status-only results, radix 0 to 63, buffer sizes 0 to 255, three idle mixes.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/itr_pkg.sv
rtl/itr_ram.sv
rtl/itr_front.sv
rtl/itr_queue.sv
rtl/itr_back.sv
rtl/integer_to_radix_text.sv
verif/testbench.sv
